### design/gppd_pkg.sv
// Package for the GPS/PPS clock discipline core.
// Holds sequencer states, request and clock-state codes, register indexes
// and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gppd_pkg;

   // request kinds
   localparam logic [1:0] REQ_GPS   = 2'd0;
   localparam logic [1:0] REQ_PPS   = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   // clock state codes
   localparam logic [1:0] CLK_UNKNOWN   = 2'd0;
   localparam logic [1:0] CLK_AVAILABLE = 2'd1;
   localparam logic [1:0] CLK_INTERNAL  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FALLBACK   = 2'd0;
   localparam logic [1:0] CSR_MAXERR_PRI = 2'd1;
   localparam logic [1:0] CSR_MAXERR_FB  = 2'd2;
   localparam logic [1:0] CSR_ALIGN      = 2'd3;

   // reset values
   localparam logic [7:0]  MAXERR_PRI_RST = 8'd5;
   localparam logic [7:0]  MAXERR_FB_RST  = 8'd10;
   localparam logic [31:0] ALIGN_RST      = 32'd100000000;

   // one pass of the shift/add unit covers a 64-bit operand
   localparam logic [5:0] STEP_LAST = 6'd63;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PGAP1,
      S_PGAP2,
      S_PCHK,
      S_PNUM,
      S_POVF,
      S_PDIV,
      S_QSUB1,
      S_QSUB2,
      S_QMUL,
      S_QFIN,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

### design/gppd_if.sv
// Channel interfaces for the GPS/PPS clock discipline core: request,
// response and CSR write. Valid/ready handshake. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gppd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] gps_time;
   logic [63:0] sys_time;
   logic [63:0] device_time;
   logic [15:0] utc_offset;

   modport source (output valid, req_type, gps_time, sys_time, device_time, utc_offset,
                   input ready);
   modport sink (input valid, req_type, gps_time, sys_time, device_time, utc_offset,
                 output ready);
endinterface

interface gppd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  clock_state;
   logic [63:0] gps_time_out;
   logic        time_valid;
   logic [15:0] utc_offset_out;

   modport source (output valid, clock_state, gps_time_out, time_valid, utc_offset_out,
                   input ready);
   modport sink (input valid, clock_state, gps_time_out, time_valid, utc_offset_out,
                 output ready);
endinterface

interface gppd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [31:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### design/gps_pps_clock_discipline_core.sv
// GPS/PPS clock discipline core: pending/committed GPS time, PPS rate
// derivation (Q16.48 divide) and time query interpolation.
// Depends on gppd_pkg and the channel interfaces in gppd_if.sv.
//
//   channel  | dir | payload                                            | transfer
//   ---------+-----+----------------------------------------------------+----------------
//   req_ch   | in  | req_type, gps_time, sys_time, device_time, utc_off | valid & ready
//   rsp_ch   | out | clock_state, gps_time_out, time_valid, utc_off_out | valid & ready
//   csr_ch   | in  | addr (register index), data                        | valid & ready
//
// GPS message: stored as pending in idle, no response. PPS without new data,
// or query at zero rate: straight to S_DONE. PPS with new data: gap, delta,
// checks, overflow test, bit-serial divide. Nonzero-rate query: delta, multiply, add.
// One 65-bit add/subtract unit does all 64-bit arithmetic; req_ch is ready only
// in idle. A result sits in the output register while the next item runs.
// Reset is synchronous; csr_ch is always ready.
`timescale 1ns / 1ps
`default_nettype none

module gps_pps_clock_discipline_core (
   input  wire logic   clock,
   input  wire logic   reset,
   gppd_req_if.sink    req_ch,
   gppd_rsp_if.source  rsp_ch,
   gppd_csr_if.sink    csr_ch
);

   gppd_pkg::state_type state_ff, state_in;

   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] wrk_ff, wrk_in;
   logic [63:0] opd_ff, opd_in;
   logic        ahead_ff, ahead_in;
   logic        commit_ff, commit_in;

   logic [63:0] rq_sys_ff, rq_sys_in;
   logic [63:0] rq_dev_ff, rq_dev_in;

   logic [1:0]  res_state_ff, res_state_in;
   logic [63:0] res_time_ff, res_time_in;
   logic        res_valid_ff, res_valid_in;

   logic [63:0] pend_gps_time_ff, pend_gps_time_in;
   logic [63:0] pend_gps_sys_ff, pend_gps_sys_in;
   logic [15:0] pend_utc_ff, pend_utc_in;
   logic [63:0] cur_gps_time_ff, cur_gps_time_in;
   logic [63:0] cur_gps_sys_ff, cur_gps_sys_in;
   logic [15:0] cur_utc_ff, cur_utc_in;
   logic [63:0] cur_pps_dev_ff, cur_pps_dev_in;
   logic [63:0] cur_pps_sys_ff, cur_pps_sys_in;
   logic [7:0]  miss_count_ff, miss_count_in;
   logic [1:0]  last_state_ff, last_state_in;
   logic [63:0] rate_q_ff, rate_q_in;

   logic        fallback_ff, fallback_in;
   logic [7:0]  max_pri_ff, max_pri_in;
   logic [7:0]  max_fb_ff, max_fb_in;
   logic [31:0] align_ff, align_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_state_ff, rsp_state_in;
   logic [63:0] rsp_time_ff, rsp_time_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0] rsp_utc_ff, rsp_utc_in;

   // shared add/subtract unit
   logic [64:0] add_a, add_b;
   logic        add_sub;
   logic [65:0] add_res;
   logic        add_carry;

   logic        req_xfer;
   logic        csr_xfer;
   logic [7:0]  err_limit;
   logic [1:0]  ok_state;
   logic        chk_ok;

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign csr_xfer  = csr_ch.valid && csr_ch.ready;
   assign err_limit = fallback_ff ? max_fb_ff : max_pri_ff;
   assign ok_state  = fallback_ff ? gppd_pkg::CLK_INTERNAL : gppd_pkg::CLK_AVAILABLE;

   assign req_ch.ready          = (state_ff == gppd_pkg::S_IDLE);
   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.clock_state    = rsp_state_ff;
   assign rsp_ch.gps_time_out   = rsp_time_ff;
   assign rsp_ch.time_valid     = rsp_tvalid_ff;
   assign rsp_ch.utc_offset_out = rsp_utc_ff;

   // operand select for the shared unit
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b1;
      case (state_ff)
         gppd_pkg::S_PGAP1: begin
            add_a = {1'b0, cur_pps_sys_ff};
            add_b = {1'b0, cur_gps_sys_ff};
         end
         gppd_pkg::S_PGAP2: begin
            add_a = {1'b0, cur_gps_sys_ff};
            add_b = {1'b0, cur_pps_sys_ff};
         end
         gppd_pkg::S_PCHK, gppd_pkg::S_QSUB1: begin
            add_a = {1'b0, rq_dev_ff};
            add_b = {1'b0, cur_pps_dev_ff};
         end
         gppd_pkg::S_QSUB2: begin
            add_a = {1'b0, cur_pps_dev_ff};
            add_b = {1'b0, rq_dev_ff};
         end
         gppd_pkg::S_PNUM: begin
            add_a = {1'b0, pend_gps_time_ff};
            add_b = {1'b0, cur_gps_time_ff};
         end
         gppd_pkg::S_POVF: begin
            add_a = {1'b0, acc_ff};
            add_b = {1'b0, opd_ff};
         end
         gppd_pkg::S_PDIV: begin
            add_a = {acc_ff, wrk_ff[63]};
            add_b = {1'b0, opd_ff};
         end
         gppd_pkg::S_QMUL: begin
            add_a   = {1'b0, acc_ff};
            add_b   = wrk_ff[0] ? {1'b0, rate_q_ff} : 65'd0;
            add_sub = 1'b0;
         end
         gppd_pkg::S_QFIN: begin
            add_a   = {1'b0, cur_gps_time_ff};
            add_b   = {1'b0, acc_ff[47:0], wrk_ff[63:48]};
            add_sub = !ahead_ff;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   // carry out of a subtract means a >= b
   assign add_res   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {65'd0, add_sub};
   assign add_carry = add_res[65];

   assign chk_ok = (cur_gps_time_ff != 64'd0) && (cur_pps_dev_ff != 64'd0)
                && (acc_ff[63:32] == 32'd0) && (acc_ff[31:0] <= align_ff)
                && (add_res[63:0] != 64'd0);

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      acc_in           = acc_ff;
      wrk_in           = wrk_ff;
      opd_in           = opd_ff;
      ahead_in         = ahead_ff;
      commit_in        = commit_ff;
      rq_sys_in        = rq_sys_ff;
      rq_dev_in        = rq_dev_ff;
      res_state_in     = res_state_ff;
      res_time_in      = res_time_ff;
      res_valid_in     = res_valid_ff;
      pend_gps_time_in = pend_gps_time_ff;
      pend_gps_sys_in  = pend_gps_sys_ff;
      pend_utc_in      = pend_utc_ff;
      cur_gps_time_in  = cur_gps_time_ff;
      cur_gps_sys_in   = cur_gps_sys_ff;
      cur_utc_in       = cur_utc_ff;
      cur_pps_dev_in   = cur_pps_dev_ff;
      cur_pps_sys_in   = cur_pps_sys_ff;
      miss_count_in    = miss_count_ff;
      last_state_in    = last_state_ff;
      rate_q_in        = rate_q_ff;
      fallback_in      = fallback_ff;
      max_pri_in       = max_pri_ff;
      max_fb_in        = max_fb_ff;
      align_in         = align_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_state_in     = rsp_state_ff;
      rsp_time_in      = rsp_time_ff;
      rsp_tvalid_in    = rsp_tvalid_ff;
      rsp_utc_in       = rsp_utc_ff;

      if (csr_xfer) begin
         case (csr_ch.addr)
            gppd_pkg::CSR_FALLBACK:   fallback_in = csr_ch.data[0];
            gppd_pkg::CSR_MAXERR_PRI: max_pri_in  = csr_ch.data[7:0];
            gppd_pkg::CSR_MAXERR_FB:  max_fb_in   = csr_ch.data[7:0];
            gppd_pkg::CSR_ALIGN:      align_in    = csr_ch.data;
            default:                  align_in    = align_ff;
         endcase
      end

      case (state_ff)
         gppd_pkg::S_IDLE: begin
            if (req_xfer) begin
               rq_sys_in    = req_ch.sys_time;
               rq_dev_in    = req_ch.device_time;
               res_time_in  = 64'd0;
               res_valid_in = 1'b0;
               commit_in    = 1'b0;
               case (req_ch.req_type)
                  gppd_pkg::REQ_GPS: begin
                     pend_gps_time_in = req_ch.gps_time;
                     pend_gps_sys_in  = req_ch.sys_time;
                     pend_utc_in      = req_ch.utc_offset;
                  end
                  gppd_pkg::REQ_PPS: begin
                     if (pend_gps_sys_ff == cur_gps_sys_ff) begin
                        // no new GPS data since the last commit
                        if (miss_count_ff < err_limit) begin
                           miss_count_in = miss_count_ff + 8'd1;
                           res_state_in  = last_state_ff;
                        end else begin
                           res_state_in  = gppd_pkg::CLK_UNKNOWN;
                        end
                        state_in = gppd_pkg::S_DONE;
                     end else begin
                        miss_count_in = 8'd0;
                        state_in      = gppd_pkg::S_PGAP1;
                     end
                  end
                  gppd_pkg::REQ_QUERY: begin
                     res_state_in = last_state_ff;
                     if (rate_q_ff == 64'd0) begin
                        state_in = gppd_pkg::S_DONE;
                     end else begin
                        state_in = gppd_pkg::S_QSUB1;
                     end
                  end
                  default: begin
                     state_in = gppd_pkg::S_IDLE;
                  end
               endcase
            end
         end

         gppd_pkg::S_PGAP1: begin
            acc_in   = add_res[63:0];
            state_in = add_carry ? gppd_pkg::S_PCHK : gppd_pkg::S_PGAP2;
         end

         gppd_pkg::S_PGAP2: begin
            acc_in   = add_res[63:0];
            state_in = gppd_pkg::S_PCHK;
         end

         gppd_pkg::S_PCHK: begin
            // acc holds the system-time gap, the unit gives the device delta
            opd_in = add_res[63:0];
            if (chk_ok) begin
               state_in = gppd_pkg::S_PNUM;
            end else begin
               res_state_in = gppd_pkg::CLK_UNKNOWN;
               commit_in    = 1'b1;
               state_in     = gppd_pkg::S_DONE;
            end
         end

         gppd_pkg::S_PNUM: begin
            // top 48 quotient bits are zero unless saturated, so the
            // remainder starts as the upper 48 bits of the numerator
            acc_in   = {16'd0, add_res[63:16]};
            wrk_in   = {add_res[15:0], 48'd0};
            state_in = gppd_pkg::S_POVF;
         end

         gppd_pkg::S_POVF: begin
            cnt_in = 6'd0;
            if (add_carry) begin
               rate_q_in    = '1;
               res_state_in = ok_state;
               commit_in    = 1'b1;
               state_in     = gppd_pkg::S_DONE;
            end else begin
               state_in = gppd_pkg::S_PDIV;
            end
         end

         gppd_pkg::S_PDIV: begin
            acc_in = add_carry ? add_res[63:0] : add_a[63:0];
            wrk_in = {wrk_ff[62:0], add_carry};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == gppd_pkg::STEP_LAST) begin
               rate_q_in    = {wrk_ff[62:0], add_carry};
               res_state_in = ok_state;
               commit_in    = 1'b1;
               state_in     = gppd_pkg::S_DONE;
            end
         end

         gppd_pkg::S_QSUB1: begin
            acc_in = 64'd0;
            cnt_in = 6'd0;
            if (add_carry) begin
               wrk_in   = add_res[63:0];
               ahead_in = (add_res[63:0] != 64'd0);
               state_in = gppd_pkg::S_QMUL;
            end else begin
               state_in = gppd_pkg::S_QSUB2;
            end
         end

         gppd_pkg::S_QSUB2: begin
            wrk_in   = add_res[63:0];
            ahead_in = 1'b0;
            state_in = gppd_pkg::S_QMUL;
         end

         gppd_pkg::S_QMUL: begin
            // product high half in acc, low half shifts into wrk
            acc_in = add_res[64:1];
            wrk_in = {add_res[0], wrk_ff[63:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == gppd_pkg::STEP_LAST) begin
               state_in = gppd_pkg::S_QFIN;
            end
         end

         gppd_pkg::S_QFIN: begin
            res_time_in  = add_res[63:0];
            res_valid_in = 1'b1;
            state_in     = gppd_pkg::S_DONE;
         end

         gppd_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_state_in  = res_state_ff;
               rsp_time_in   = res_time_ff;
               rsp_tvalid_in = res_valid_ff;
               rsp_utc_in    = commit_ff ? pend_utc_ff : cur_utc_ff;
               if (commit_ff) begin
                  cur_pps_dev_in  = rq_dev_ff;
                  cur_pps_sys_in  = rq_sys_ff;
                  last_state_in   = res_state_ff;
                  cur_gps_time_in = pend_gps_time_ff;
                  cur_gps_sys_in  = pend_gps_sys_ff;
                  cur_utc_in      = pend_utc_ff;
               end
               state_in = gppd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = gppd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= gppd_pkg::S_IDLE;
         pend_gps_time_ff <= 64'd0;
         pend_gps_sys_ff  <= 64'd0;
         pend_utc_ff      <= 16'd0;
         cur_gps_time_ff  <= 64'd0;
         cur_gps_sys_ff   <= 64'd0;
         cur_utc_ff       <= 16'd0;
         cur_pps_dev_ff   <= 64'd0;
         cur_pps_sys_ff   <= 64'd0;
         miss_count_ff    <= gppd_pkg::MAXERR_PRI_RST;
         last_state_ff    <= gppd_pkg::CLK_UNKNOWN;
         rate_q_ff        <= 64'd0;
         fallback_ff      <= 1'b0;
         max_pri_ff       <= gppd_pkg::MAXERR_PRI_RST;
         max_fb_ff        <= gppd_pkg::MAXERR_FB_RST;
         align_ff         <= gppd_pkg::ALIGN_RST;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pend_gps_time_ff <= pend_gps_time_in;
         pend_gps_sys_ff  <= pend_gps_sys_in;
         pend_utc_ff      <= pend_utc_in;
         cur_gps_time_ff  <= cur_gps_time_in;
         cur_gps_sys_ff   <= cur_gps_sys_in;
         cur_utc_ff       <= cur_utc_in;
         cur_pps_dev_ff   <= cur_pps_dev_in;
         cur_pps_sys_ff   <= cur_pps_sys_in;
         miss_count_ff    <= miss_count_in;
         last_state_ff    <= last_state_in;
         rate_q_ff        <= rate_q_in;
         fallback_ff      <= fallback_in;
         max_pri_ff       <= max_pri_in;
         max_fb_ff        <= max_fb_in;
         align_ff         <= align_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      wrk_ff        <= wrk_in;
      opd_ff        <= opd_in;
      ahead_ff      <= ahead_in;
      commit_ff     <= commit_in;
      rq_sys_ff     <= rq_sys_in;
      rq_dev_ff     <= rq_dev_in;
      res_state_ff  <= res_state_in;
      res_time_ff   <= res_time_in;
      res_valid_ff  <= res_valid_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_tvalid_ff <= rsp_tvalid_in;
      rsp_utc_ff    <= rsp_utc_in;
   end

endmodule

`default_nettype wire
